FILE: hw/rtl/safs_pkg.sv
// Package for the sprite animation frame sequencer: widths, codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package safs_pkg;

  // Default width of a time amount (tick and frame period)
  localparam int unsigned TIME_BITS_DEF = 16;
  // Longest supported sequence
  localparam int unsigned MAX_FRAMES    = 256;

  localparam int unsigned FRAME_W = 8;  // current frame index
  localparam int unsigned COUNT_W = 9;  // frame count register
  localparam int unsigned IDX_W   = 2;  // config register index

  // Effective frame count limit: MAX_FRAMES and the frame index range
  localparam logic [COUNT_W-1:0] FRAME_CAP =
      COUNT_W'((MAX_FRAMES < 256) ? MAX_FRAMES : 256);

  // Config register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_PERIOD = 2'd0,
    REG_PLAY_MODE    = 2'd1,
    REG_FRAME_COUNT  = 2'd2
  } cfg_reg_e;

  // Play modes; the unused code runs as loop
  typedef enum logic [1:0] {
    MODE_LOOP = 2'd0,
    MODE_ONCE = 2'd1,
    MODE_PING = 2'd2
  } mode_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,  // waiting for a tick
    ST_DRAIN = 2'd1,  // draining one period per cycle
    ST_HOLD  = 2'd2   // result ready, output register still occupied
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // take the tick, add it to the accumulator when active
    logic step;  // drain one period and advance the frame
    logic emit;  // load the output register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic drain_req;  // acc >= period while playing with nonzero count and period
    logic out_busy;   // output word still waiting and not taken this cycle
  } dp_status_t;

endpackage

FILE: hw/rtl/sprite_animation_frame_sequencer.sv
// Top level of the sprite animation frame sequencer.
// Instantiates safs_ctrl and safs_dpath; depends on safs_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i/in_ready_o, time_step_i): one word per display
//   tick carrying the elapsed time. Output channel (out_valid_o/out_ready_i)
//   returns one word per tick: frame index, playing, reversing, frame valid.
//   Config port (cfg_we_i, cfg_idx_i, cfg_wdata_i): 0 frame period,
//   1 play mode, 2 frame count; write only while no tick is in flight.
// Timing
//   A tick is added to the accumulator on acceptance while the sequence is
//   active; the drain loop then subtracts one period per cycle, moving the
//   frame for each, until less than a period is left or play stops, and the
//   result is then loaded in the output register. One tick is processed at
//   a time; the next tick is taken once that result is loaded.
// Reset
//   Clears the config registers, accumulator, frame and direction, sets the
//   playing flag; no clearing pass, a tick can be taken right after reset.
// Back-pressure
//   A result waiting in the output register does not block the next tick;
//   if it is still not taken when the next result is ready, the sequencer
//   waits until the receiver takes it.
module sprite_animation_frame_sequencer import safs_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF,
  localparam int unsigned CFG_W    = (TIME_BITS > COUNT_W) ? TIME_BITS : COUNT_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TIME_BITS-1:0] time_step_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FRAME_W-1:0]   frame_index_o,
  output logic                 is_playing_o,
  output logic                 is_reversing_o,
  output logic                 frame_valid_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing control
  safs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Accumulator, frame state and output register
  safs_dpath #(
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .time_step_i    (time_step_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_index_o  (frame_index_o),
    .is_playing_o   (is_playing_o),
    .is_reversing_o (is_reversing_o),
    .frame_valid_o  (frame_valid_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule

FILE: hw/rtl/safs_ctrl.sv
// Controller state machine of the sprite animation frame sequencer.
// Depends on safs_pkg (state_e, dp_cmd_t, dp_status_t).
`timescale 1ns / 1ps

module safs_ctrl import safs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.drain_req) begin
          state_d = status_i.out_busy ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DRAIN: begin
        cmd_o.step = status_i.drain_req;
        cmd_o.emit = !status_i.drain_req && !status_i.out_busy;
      end
      ST_HOLD: begin
        cmd_o.emit = !status_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/safs_dpath.sv
// Datapath of the sprite animation frame sequencer: config registers,
// accumulator, frame/direction/run state and the output register.
// Depends on safs_pkg.
`timescale 1ns / 1ps

module safs_dpath import safs_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF,
  localparam int unsigned ACC_W    = TIME_BITS + 1,
  localparam int unsigned CFG_W    = (TIME_BITS > COUNT_W) ? TIME_BITS : COUNT_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config
  input  logic                 cfg_we_i,
  input  logic [IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // tick
  input  logic [TIME_BITS-1:0] time_step_i,
  // result
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FRAME_W-1:0]   frame_index_o,
  output logic                 is_playing_o,
  output logic                 is_reversing_o,
  output logic                 frame_valid_o,
  // controller link
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o
);

  logic [TIME_BITS-1:0] frame_period_q;
  mode_e                play_mode_q;
  logic [COUNT_W-1:0]   frame_count_q;

  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [FRAME_W-1:0]   frame_q, frame_d;
  logic                 back_q, back_d;
  logic                 run_q, run_d;

  logic                 out_valid_q;
  logic [FRAME_W-1:0]   out_frame_q;
  logic                 out_run_q, out_back_q, out_fvalid_q;

  logic [COUNT_W-1:0]   count;
  logic [FRAME_W-1:0]   last;
  logic                 active;
  logic                 fvalid;

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_period_q <= '0;
      play_mode_q    <= MODE_LOOP;
      frame_count_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_PERIOD: frame_period_q <= cfg_wdata_i[TIME_BITS-1:0];
        REG_PLAY_MODE:    play_mode_q    <= mode_e'(cfg_wdata_i[1:0]);
        REG_FRAME_COUNT:  frame_count_q  <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective count, last frame, playing condition
  assign count  = (frame_count_q > FRAME_CAP) ? FRAME_CAP : frame_count_q;
  assign last   = FRAME_W'(count - COUNT_W'(1));
  assign active = (count != '0) && run_q && (frame_period_q != '0);

  assign status_o.drain_req = active && (acc_q >= ACC_W'(frame_period_q));
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  // Accumulate a tick, drain a period per step, move frame or stop
  always_comb begin
    acc_d   = acc_q;
    frame_d = frame_q;
    back_d  = back_q;
    run_d   = run_q;
    if (cmd_i.load) begin
      if (active) begin
        acc_d = acc_q + ACC_W'(time_step_i);
      end
    end else if (cmd_i.step) begin
      acc_d = acc_q - ACC_W'(frame_period_q);
      case (play_mode_q)
        MODE_ONCE: begin
          if (frame_q >= last) begin
            run_d = 1'b0;
          end else begin
            frame_d = frame_q + 1'b1;
          end
        end
        MODE_PING: begin
          if (back_q) begin
            if (frame_q == '0) begin
              back_d  = 1'b0;
              frame_d = (last == '0) ? '0 : FRAME_W'(1);
            end else begin
              frame_d = frame_q - 1'b1;
            end
          end else if (frame_q >= last) begin
            back_d  = 1'b1;
            frame_d = (last == '0) ? '0 : last - 1'b1;
          end else begin
            frame_d = frame_q + 1'b1;
          end
        end
        default: begin
          frame_d = (frame_q >= last) ? '0 : frame_q + 1'b1;
        end
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      frame_q <= '0;
      back_q  <= 1'b0;
      run_q   <= 1'b1;
    end else begin
      acc_q   <= acc_d;
      frame_q <= frame_d;
      back_q  <= back_d;
      run_q   <= run_d;
    end
  end

  // Output word
  assign fvalid = (count != '0) && ({1'b0, frame_q} < count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_frame_q  <= fvalid ? frame_q : '0;
      out_run_q    <= run_q;
      out_back_q   <= back_q;
      out_fvalid_q <= fvalid;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_index_o  = out_frame_q;
  assign is_playing_o   = out_run_q;
  assign is_reversing_o = out_back_q;
  assign frame_valid_o  = out_fvalid_q;

endmodule

FILE: hw/rtl/safs_checker.sv
// Port-level checks for the sprite animation frame sequencer, bound to the top.
// Depends on safs_pkg (FRAME_W).
`timescale 1ns / 1ps

module safs_checker import safs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [FRAME_W-1:0] frame_index_o,
  input logic               is_playing_o,
  input logic               is_reversing_o,
  input logic               frame_valid_o
);

  // A tick taken keeps the sequencer busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after accepting a tick");

  // A new result only appears after the sequencer was busy
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a tick being processed");

  // No frame number without a valid frame
  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_valid_o |-> frame_index_o == '0)
    else $error("frame index nonzero while frame invalid");

  // Stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_index_o)
      && $stable(is_playing_o) && $stable(is_reversing_o) && $stable(frame_valid_o))
    else $error("output word dropped or changed while stalled");

endmodule

bind sprite_animation_frame_sequencer safs_checker u_safs_checker (.*);
